@@ hw/rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int SIZE_W = 16;

    typedef enum logic [1:0] {
        FN_FIRST = 2'd0,
        FN_BEST  = 2'd1,
        FN_WORST = 2'd2,
        FN_FREE  = 2'd3
    } t_pfa_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_pfa_status;

    typedef struct packed {
        t_pfa_func         func;
        logic [SIZE_W-1:0] request_size;
        logic [SIZE_W-1:0] free_address;
    } t_pfa_in;

    typedef struct packed {
        t_pfa_status       status;
        logic [SIZE_W-1:0] granted_address;
    } t_pfa_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_APPEND,
        S_RESULT
    } t_pfa_state;

    typedef struct packed {
        logic capture;
        logic rd;
        logic decide;
        logic append;
        logic out_load;
    } t_pfa_cmd;

    typedef struct packed {
        logic last_rd;
        logic do_append;
        logic out_stall;
    } t_pfa_sts;

endpackage

`default_nettype wire

@@ hw/rtl/pfa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_pfa_sts i_sts,
    output t_pfa_cmd      o_cmd
);

    t_pfa_state r_state;
    t_pfa_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.do_append ? S_APPEND : S_RESULT;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    input  wire t_pfa_in           i_in,
    input  wire t_pfa_cmd          i_cmd,
    output t_pfa_sts               o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_pfa_out               o_out
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;
    localparam logic [SIZE_W-1:0] SIZE_MASK = (ADDR_BITS >= SIZE_W) ? {SIZE_W{1'b1}} :
        SIZE_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic [ADDR_BITS-1:0] r_mem_start [TABLE_DEPTH];
    logic [SIZE_W-1:0]    r_mem_size  [TABLE_DEPTH];
    logic                 r_mem_used  [TABLE_DEPTH];

    logic [SIZE_W-1:0]    r_pool;
    logic                 r_fresh;
    logic [CW-1:0]        r_count;

    t_pfa_func            r_func;
    logic [SIZE_W-1:0]    r_req;
    logic [SIZE_W-1:0]    r_addr;

    logic [IW-1:0]        r_idx;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_fresh;
    logic [ADDR_BITS-1:0] r_rd_start;
    logic [SIZE_W-1:0]    r_rd_size;
    logic                 r_rd_used;

    logic                 r_hit;
    logic [IW-1:0]        r_k_idx;
    logic [ADDR_BITS-1:0] r_k_start;
    logic [SIZE_W-1:0]    r_k_size;

    t_pfa_status          r_res_status;
    logic [SIZE_W-1:0]    r_res_addr;
    logic                 r_out_valid;
    t_pfa_out             r_out;

    logic [ADDR_BITS-1:0] e_start;
    logic [SIZE_W-1:0]    e_size;
    logic                 e_used;
    logic                 is_alloc;
    logic                 take;
    logic [SIZE_W-1:0]    rest;
    logic                 full;
    t_pfa_status          dec_status;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [ADDR_BITS-1:0] wr_start;
    logic [SIZE_W-1:0]    wr_size;
    logic                 wr_used;

    assign e_start = r_rd_fresh ? '0 : r_rd_start;
    assign e_size  = r_rd_fresh ? r_pool : r_rd_size;
    assign e_used  = r_rd_fresh ? 1'b0 : r_rd_used;

    assign is_alloc = (r_func != FN_FREE);

    always_comb begin
        take = 1'b0;
        if (is_alloc) begin
            if (!e_used && (e_size >= r_req) && (r_req != '0)) begin
                take = !r_hit
                    || ((r_func == FN_BEST) && (e_size < r_k_size))
                    || ((r_func == FN_WORST) && (e_size > r_k_size));
            end
        end else begin
            take = !r_hit && e_used && (XW'(e_start) == XW'(r_addr));
        end
    end

    assign rest = r_k_size - r_req;
    assign full = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        if (!is_alloc) begin
            dec_status = r_hit ? ST_OK : ST_NOTFOUND;
        end else if (!r_hit) begin
            dec_status = ST_NOFIT;
        end else if ((rest != '0) && full) begin
            dec_status = ST_FULL;
        end else begin
            dec_status = ST_OK;
        end
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_idx   = r_k_idx;
        wr_start = r_k_start;
        wr_size  = is_alloc ? r_req : r_k_size;
        wr_used  = is_alloc;
        if (i_cmd.append) begin
            wr_en    = 1'b1;
            wr_idx   = r_count[IW-1:0];
            wr_start = r_k_start + ADDR_BITS'(r_req);
            wr_size  = rest;
            wr_used  = 1'b0;
        end else if (i_cmd.decide && (dec_status == ST_OK) && r_hit) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_start[wr_idx] <= wr_start;
            r_mem_size[wr_idx]  <= wr_size;
            r_mem_used[wr_idx]  <= wr_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_start <= r_mem_start[r_idx];
            r_rd_size  <= r_mem_size[r_idx];
            r_rd_used  <= r_mem_used[r_idx];
            r_rd_fresh <= r_fresh && (r_idx == '0);
            r_rd_idx   <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool  <= SIZE_MASK;
            r_fresh <= 1'b1;
            r_count <= CW'(1);
        end else if (i_cfg_we) begin
            r_pool  <= i_cfg_wdata & SIZE_MASK;
            r_fresh <= 1'b1;
            r_count <= CW'(1);
        end else begin
            if (wr_en && (wr_idx == '0)) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.capture) begin
                r_hit <= 1'b0;
            end else if (r_rd_vld && take) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_in.func;
            r_req  <= i_in.request_size;
            r_addr <= i_in.free_address;
            r_idx  <= '0;
        end else if (i_cmd.rd) begin
            r_idx <= r_idx + IW'(1);
        end
        if (r_rd_vld && take) begin
            r_k_idx   <= r_rd_idx;
            r_k_start <= e_start;
            r_k_size  <= e_size;
        end
        if (i_cmd.decide) begin
            r_res_status <= dec_status;
            r_res_addr   <= (is_alloc && (dec_status == ST_OK)) ? SIZE_W'(r_k_start) : '0;
        end
        if (i_cmd.out_load) begin
            r_out.status          <= r_res_status;
            r_out.granted_address <= r_res_addr;
        end
    end

    assign o_sts.last_rd   = (CW'(r_idx) == (r_count - CW'(1)));
    assign o_sts.do_append = is_alloc && r_hit && (rest != '0) && !full;
    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/partition_fit_allocator_top.sv @@
// Channel  | Valid       | Ready       | Payload
// ---------+-------------+-------------+------------------------------
// input    | i_in_valid  | o_in_ready  | i_in  (func, request_size, free_address)
// output   | o_out_valid | i_out_ready | o_out (status, granted_address)
// config   | i_cfg_we    | -           | i_cfg_wdata (pool_size)
//
// One transaction at a time; the table scan reads one entry per cycle over all
// part_count entries (32 with a full table of 32).
// Allocations that split a partition pass through an append state for the second write.
// Reset and a pool_size write leave one free partition covering the pool.
// A new request is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_pfa_in           i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_pfa_out               o_out
);

    t_pfa_cmd cmd;
    t_pfa_sts sts;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
